/* hw/rtl/address_range_table_lookup_core_defines.svh */
// Assertion macros shared by the address range table lookup RTL.
`ifndef ADDRESS_RANGE_TABLE_LOOKUP_CORE_DEFINES_SVH
`define ADDRESS_RANGE_TABLE_LOOKUP_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ARLT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ARLT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/arlt_pkg.sv */
// Package with sizes, codes and structs of the address range table lookup.
`default_nettype none

package arlt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W      = 64;
   localparam int ID_W        = 8;
   localparam int NUM_GROUPS  = 8;
   localparam int GROUP_SIZE  = (TABLE_DEPTH + NUM_GROUPS - 1) / NUM_GROUPS;

   typedef enum logic [1:0] {
      REQ_CLEAR  = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_LOOKUP = 2'd2
   } arlt_req_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_EMPTY    = 2'd1,
      STAT_OVERFLOW = 2'd2,
      STAT_FULL     = 2'd3
   } arlt_status_type;

   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] end_addr;
      logic [ID_W-1:0]   id;
   } arlt_entry_type;

   // Control and data broadcast to every cell of the chain.
   typedef struct packed {
      logic              insert_en;
      logic              sample;
      logic [CNT_W-1:0]  count;
      logic [ADDR_W-1:0] addr;
      arlt_entry_type    entry;
   } arlt_bcast_type;

   typedef struct packed {
      logic [6:0]        entry_count;
      logic [ADDR_W-1:0] found_end;
      logic [ADDR_W-1:0] found_base;
      logic [ID_W-1:0]   found_id;
      logic [5:0]        found_index;
      logic              hit;
      arlt_status_type   status;
   } arlt_rsp_type;

endpackage

`default_nettype wire

/* hw/rtl/arlt_cell.sv */
// One cell of the sorted range chain: holds one entry, shifts and matches.
`default_nettype none

module arlt_cell (
   input  logic                          clock,
   input  logic [arlt_pkg::IDX_W-1:0]    cell_index,
   input  arlt_pkg::arlt_bcast_type      bcast,
   input  arlt_pkg::arlt_entry_type      left_entry,
   input  logic                          left_gt,
   input  logic                          right_le,
   output arlt_pkg::arlt_entry_type      entry,
   output logic                          gt,
   output logic                          le,
   output logic                          sel
);
   import arlt_pkg::*;

   arlt_entry_type entry_ff;
   arlt_entry_type entry_in;
   logic           sel_ff;
   logic           sel_in;
   logic           occupied;
   logic           at_end;

   always_comb begin
      occupied = CNT_W'(cell_index) < bcast.count;
      at_end   = CNT_W'(cell_index) == bcast.count;
      gt       = occupied && (entry_ff.base > bcast.entry.base);
      le       = occupied && (entry_ff.base <= bcast.addr);

      // The chain is sorted, so le runs ones then zeros; the last one is the candidate.
      sel_in = bcast.sample ? (le && !right_le) : sel_ff;

      // A greater left neighbor moves right; the first slot past the smaller or equal bases takes the new entry.
      entry_in = entry_ff;
      if (bcast.insert_en) begin
         if (left_gt) begin
            entry_in = left_entry;
         end else if (gt || at_end) begin
            entry_in = bcast.entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      sel_ff   <= sel_in;
   end

   assign entry = entry_ff;
   assign sel   = sel_ff;

endmodule

`default_nettype wire

/* hw/rtl/arlt_select.sv */
// Two-stage registered OR tree that picks the selected cell's entry and index.
`default_nettype none

module arlt_select (
   input  logic                              clock,
   input  logic [arlt_pkg::TABLE_DEPTH-1:0]  sel,
   input  arlt_pkg::arlt_entry_type          entries [arlt_pkg::TABLE_DEPTH],
   output logic                              found_valid,
   output arlt_pkg::arlt_entry_type          found_entry,
   output logic [arlt_pkg::IDX_W-1:0]        found_index
);
   import arlt_pkg::*;

   localparam int ENTRY_W = $bits(arlt_entry_type);

   logic               grp_valid_ff [NUM_GROUPS];
   logic               grp_valid_in [NUM_GROUPS];
   logic [ENTRY_W-1:0] grp_entry_ff [NUM_GROUPS];
   logic [ENTRY_W-1:0] grp_entry_in [NUM_GROUPS];
   logic [IDX_W-1:0]   grp_index_ff [NUM_GROUPS];
   logic [IDX_W-1:0]   grp_index_in [NUM_GROUPS];
   logic               fin_valid_ff;
   logic               fin_valid_in;
   logic [ENTRY_W-1:0] fin_entry_ff;
   logic [ENTRY_W-1:0] fin_entry_in;
   logic [IDX_W-1:0]   fin_index_ff;
   logic [IDX_W-1:0]   fin_index_in;

   // At most one select flag is set, so OR-ing masked entries yields the chosen one.
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_valid_in[g] = 1'b0;
         grp_entry_in[g] = '0;
         grp_index_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if ((g * GROUP_SIZE + k) < TABLE_DEPTH) begin
               if (sel[g * GROUP_SIZE + k]) begin
                  grp_valid_in[g] = 1'b1;
                  grp_entry_in[g] = grp_entry_in[g] | entries[g * GROUP_SIZE + k];
                  grp_index_in[g] = grp_index_in[g] | IDX_W'(g * GROUP_SIZE + k);
               end
            end
         end
      end
   end

   always_comb begin
      fin_valid_in = 1'b0;
      fin_entry_in = '0;
      fin_index_in = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         fin_valid_in = fin_valid_in | grp_valid_ff[g];
         fin_entry_in = fin_entry_in | grp_entry_ff[g];
         fin_index_in = fin_index_in | grp_index_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_valid_ff[g] <= grp_valid_in[g];
         grp_entry_ff[g] <= grp_entry_in[g];
         grp_index_ff[g] <= grp_index_in[g];
      end
      fin_valid_ff <= fin_valid_in;
      fin_entry_ff <= fin_entry_in;
      fin_index_ff <= fin_index_in;
   end

   assign found_valid = fin_valid_ff;
   assign found_entry = fin_entry_ff;
   assign found_index = fin_index_ff;

endmodule

`default_nettype wire

/* hw/rtl/address_range_table_lookup_core.sv */
// One request is in flight at a time: req_tready stays low until its result has moved
// from the pending register into the output register. The cells compare in the accept
// cycle, then come two OR-tree stages, a hit compare and a skid stage.
// Clear resets the entry count and insert updates the cell chain in the accept cycle itself.
// Reset (synchronous, active high) empties the table and drops all pending transactions.
`default_nettype none
`include "address_range_table_lookup_core_defines.svh"

module address_range_table_lookup_core (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // req_tdata: entry_base[63:0], entry_size[127:64], module_id[135:128],
   //            lookup_address[199:136]
   input  logic [199:0]  req_tdata,
   // req_tuser: req_type[1:0]
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // rsp_tdata: status[1:0], hit[2], found_index[8:3], found_id[16:9],
   //            found_base[80:17], found_end[144:81], entry_count[151:145]
   output logic [151:0]  rsp_tdata
);
   import arlt_pkg::*;

   logic              accept;
   arlt_req_type      req_kind;
   logic [ADDR_W-1:0] req_base;
   logic [ADDR_W-1:0] req_size;
   logic [ID_W-1:0]   req_id;
   logic [ADDR_W-1:0] req_addr;
   arlt_status_type   ins_status;
   arlt_bcast_type    bcast;

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              v1_ff, v2_ff, v3_ff;
   logic              pend_valid_ff;
   logic              pend_valid_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              rsp_load;
   arlt_rsp_type      pend_ff;
   arlt_rsp_type      pend_in;
   arlt_rsp_type      rsp_ff;

   arlt_req_type      item_kind_ff;
   arlt_status_type   item_status_ff;
   logic [ADDR_W-1:0] item_addr_ff;

   arlt_entry_type    cell_entry [TABLE_DEPTH];
   arlt_entry_type    left_entry [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] left_gt;
   logic [TABLE_DEPTH-1:0] right_le;
   logic [TABLE_DEPTH-1:0] cell_gt;
   logic [TABLE_DEPTH-1:0] cell_le;
   logic [TABLE_DEPTH-1:0] cell_sel;

   logic              found_valid;
   arlt_entry_type    found_entry;
   logic [IDX_W-1:0]  found_index;
   logic              lookup_hit;

   assign req_kind   = arlt_req_type'(req_tuser);
   assign req_base   = req_tdata[63:0];
   assign req_size   = req_tdata[127:64];
   assign req_id     = req_tdata[135:128];
   assign req_addr   = req_tdata[199:136];

   assign req_tready = !v1_ff && !v2_ff && !v3_ff && !pend_valid_ff;
   assign accept     = req_tvalid && req_tready;

   // Rejection checks in priority order: empty range, end overflow, table full.
   always_comb begin
      if (req_base == '0 || req_size == '0) begin
         ins_status = STAT_EMPTY;
      end else if (req_base > ~req_size) begin
         ins_status = STAT_OVERFLOW;
      end else if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
         ins_status = STAT_FULL;
      end else begin
         ins_status = STAT_OK;
      end
   end

   always_comb begin
      bcast.insert_en      = accept && (req_kind == REQ_INSERT) && (ins_status == STAT_OK);
      bcast.sample         = accept;
      bcast.count          = count_ff;
      bcast.addr           = req_addr;
      bcast.entry.base     = req_base;
      bcast.entry.end_addr = req_base + req_size;
      bcast.entry.id       = req_id;
   end

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         case (req_kind)
            REQ_CLEAR:  count_in = '0;
            REQ_INSERT: begin
               if (ins_status == STAT_OK) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            default:    count_in = count_ff;
         endcase
      end
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_entry[i] = bcast.entry;
         assign left_gt[i]    = 1'b0;
      end else begin : g_inner
         assign left_entry[i] = cell_entry[i-1];
         assign left_gt[i]    = cell_gt[i-1];
      end
      if (i == TABLE_DEPTH - 1) begin : g_last
         assign right_le[i] = 1'b0;
      end else begin : g_body
         assign right_le[i] = cell_le[i+1];
      end

      arlt_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_W'(i)),
         .bcast      (bcast),
         .left_entry (left_entry[i]),
         .left_gt    (left_gt[i]),
         .right_le   (right_le[i]),
         .entry      (cell_entry[i]),
         .gt         (cell_gt[i]),
         .le         (cell_le[i]),
         .sel        (cell_sel[i])
      );
   end

   arlt_select u_select (
      .clock       (clock),
      .sel         (cell_sel),
      .entries     (cell_entry),
      .found_valid (found_valid),
      .found_entry (found_entry),
      .found_index (found_index)
   );

   assign lookup_hit = (item_kind_ff == REQ_LOOKUP) && found_valid &&
                       (item_addr_ff < found_entry.end_addr);

   always_comb begin
      pend_in             = '0;
      pend_in.status      = (item_kind_ff == REQ_INSERT) ? item_status_ff : STAT_OK;
      pend_in.entry_count = 7'(count_ff);
      if (lookup_hit) begin
         pend_in.hit         = 1'b1;
         pend_in.found_index = 6'(found_index);
         pend_in.found_id    = found_entry.id;
         pend_in.found_base  = found_entry.base;
         pend_in.found_end   = found_entry.end_addr;
      end
   end

   assign rsp_load = pend_valid_ff && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (v3_ff) begin
         pend_valid_in = 1'b1;
      end else if (rsp_load) begin
         pend_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         v1_ff         <= accept;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_kind_ff   <= req_kind;
         item_status_ff <= ins_status;
         item_addr_ff   <= req_addr;
      end
      if (v3_ff) begin
         pend_ff <= pend_in;
      end
      if (rsp_load) begin
         rsp_ff <= pend_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   `ARLT_ASSERT_NXT(a_busy_after_accept, clock, reset, accept, !req_tready,
      "request accepted while a transaction was still in flight")
   `ARLT_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH),
      "stored entry count exceeds table depth")
   `ARLT_ASSERT_IMP(a_sel_onehot, clock, reset, v1_ff, $onehot0(cell_sel),
      "more than one cell selected for a lookup")
   `ARLT_ASSERT_NXT(a_pend_hold, clock, reset, pend_valid_ff && rsp_valid_ff && !rsp_tready,
      pend_valid_ff && $stable(pend_ff), "pending result lost while output stalled")
   `ARLT_ASSERT_IMP(a_hit_status, clock, reset, rsp_valid_ff && rsp_ff.hit,
      rsp_ff.status == STAT_OK, "hit reported together with a nonzero status")

endmodule

`default_nettype wire
